>>> rtl/core/pidtw_pkg.sv
// Package for the PID steering controller with twiddle tuning: constants and the sequencer states.
`default_nettype none
package pidtw_pkg;

  localparam int NUM_GAINS = 3;
  localparam logic [23:0] DELTA_INIT = 24'd6554;
  localparam logic [23:0] G_MAX = 24'h7FFFFF;
  localparam logic [47:0] SQ_MAX = 48'hFFFFFFFFFFFF;
  localparam logic [5:0] MUL_LAST = 6'd31;
  localparam logic [5:0] DIV_LAST = 6'd47;

  // configuration register indexes
  localparam logic [2:0] CFG_KP_INIT = 3'd0;
  localparam logic [2:0] CFG_KD_INIT = 3'd1;
  localparam logic [2:0] CFG_KI_INIT = 3'd2;
  localparam logic [2:0] CFG_WARMUP = 3'd3;
  localparam logic [2:0] CFG_RUN_LEN = 3'd4;
  localparam logic [2:0] CFG_ERR_LIM = 3'd5;
  localparam logic [2:0] CFG_STEER_LO = 3'd6;
  localparam logic [2:0] CFG_STEER_HI = 3'd7;

  localparam logic OP_SAMPLE = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_MUL,
    ST_SQ_ADD,
    ST_MUL,
    ST_STEER,
    ST_DIV,
    ST_CMP,
    ST_DSTORE,
    ST_NEXT,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

>>> rtl/core/pid_steer_with_twiddle_tuning.sv
// PID steering controller with twiddle gain search, bit-serial multiply and divide.
// Operation: a sample runs a serial e*e, then three serial gain products into one accumulator;
//   an evaluate that continues goes straight to the result, and one that ends runs a serial mean
//   divide (skipped within warm-up) and may then run a serial delta scaling.
// Throughput: one item at a time; the next item is taken once the result sits in the output reg.
// Reset: synchronous active-low rst_n restores register defaults, gains 0, deltas to DELTA_INIT.
`default_nettype none
module pid_steer_with_twiddle_tuning
  import pidtw_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [15:0]  in_tdata,   // cross_track_error[15:0]
  input  wire logic         in_tuser,   // op[0]
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // steer_out[15:0], run_continues[16], tuned_gain_index[18:17], gain_p_now[42:19],
  // gain_d_now[66:43], gain_i_now[90:67], trial_count[106:91], zero pad[111:107]
  output logic [111:0]      out_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [23:0]  cfg_data
);

  state_t state_r, state_nxt;

  logic [15:0] warm_r, runlen_r;
  logic signed [15:0] elim_r, slo_r, shi_r;
  logic signed [23:0] gp_r, gd_r, gi_r;
  logic [23:0] dp_r, dd_r, di_r;
  logic signed [15:0] last_err_r, prev_err_r, steer_r, e_r;
  logic signed [16:0] de_r;
  logic signed [31:0] esum_r;
  logic [47:0] sq_r, best_r, quo_r;
  logic [15:0] step_r, trials_r, rem_r, dvsr_r;
  logic [1:0] idx_r, pass_r;
  logic pos_r, cont_r, div_scale_r, out_valid_r;
  logic signed [63:0] acc_r, mcand_r;
  logic [31:0] mplier_r;
  logic [5:0] cnt_r;
  logic [111:0] out_data_r;

  function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
    if (v > 26'sd8388607) return 24'sh7FFFFF;
    if (v < -26'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  logic signed [23:0] cur_gain;
  logic [23:0] cur_delta;
  always_comb begin
    unique case (idx_r)
      2'd0: begin cur_gain = gp_r; cur_delta = dp_r; end
      2'd1: begin cur_gain = gd_r; cur_delta = dd_r; end
      default: begin cur_gain = gi_r; cur_delta = di_r; end
    endcase
  end

  logic signed [25:0] gain_minus2, gain_plus;
  logic [27:0] d_x11, d_x9;
  assign gain_minus2 = {{2{cur_gain[23]}}, cur_gain} - {1'b0, cur_delta, 1'b0};
  assign gain_plus   = {{2{cur_gain[23]}}, cur_gain} + {2'b00, cur_delta};
  assign d_x11 = {1'b0, cur_delta, 3'b000} + {3'b000, cur_delta, 1'b0}
               + {4'b0000, cur_delta} + 28'd5;
  assign d_x9  = {1'b0, cur_delta, 3'b000} + {4'b0000, cur_delta} + 28'd5;

  logic eval_cont, improve, out_free;
  assign eval_cont = (step_r <= warm_r && last_err_r < elim_r && steer_r >= slo_r
                      && steer_r <= shi_r) || (step_r > warm_r && step_r < runlen_r);
  assign improve  = quo_r < best_r;
  assign out_free = !out_valid_r || out_tready;

  // serial multiply step: subtract at the sign bit of the multiplier
  logic signed [63:0] mul_add;
  assign mul_add = !mplier_r[0] ? 64'sd0 : (cnt_r == MUL_LAST ? -mcand_r : mcand_r);

  // restoring divide step
  logic [16:0] rem_sh;
  logic rem_ge;
  assign rem_sh = {rem_r, quo_r[47]};
  assign rem_ge = rem_sh >= {1'b0, dvsr_r};

  // sample front end
  logic signed [15:0] e_in;
  logic signed [32:0] esum_wide;
  logic signed [31:0] esum_new;
  logic [15:0] step_inc;
  assign e_in = $signed(in_tdata[15:0]);
  assign esum_wide = {esum_r[31], esum_r} + {{17{e_in[15]}}, e_in};
  assign esum_new = (esum_wide[32] != esum_wide[31])
                  ? (esum_wide[32] ? 32'sh80000000 : 32'sh7FFFFFFF) : esum_wide[31:0];
  assign step_inc = (step_r == 16'hFFFF) ? step_r : step_r + 16'd1;

  logic [48:0] sq_wide;
  assign sq_wide = {1'b0, sq_r} + {17'd0, acc_r[31:0]};

  logic signed [63:0] steer_t;
  logic signed [47:0] steer_s;
  assign steer_t = 64'sd32768 - acc_r;
  assign steer_s = steer_t[63:16];

  logic [23:0] delta_sat;
  assign delta_sat = (quo_r[47:23] != 25'd0) ? G_MAX : quo_r[23:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_tvalid) begin
        if (in_tuser == OP_SAMPLE) state_nxt = ST_SQ_MUL;
        else if (eval_cont) state_nxt = ST_DONE;
        else if (step_r <= warm_r) state_nxt = ST_CMP;
        else state_nxt = ST_DIV;
      end
      ST_SQ_MUL: if (cnt_r == MUL_LAST) state_nxt = ST_SQ_ADD;
      ST_SQ_ADD: state_nxt = ST_MUL;
      ST_MUL:    if (cnt_r == MUL_LAST && pass_r == 2'd2) state_nxt = ST_STEER;
      ST_STEER:  state_nxt = ST_DONE;
      ST_DIV:    if (cnt_r == DIV_LAST) state_nxt = div_scale_r ? ST_DSTORE : ST_CMP;
      ST_CMP:    state_nxt = (improve || !pos_r) ? ST_DIV : ST_DONE;
      ST_DSTORE: state_nxt = ST_NEXT;
      ST_NEXT:   state_nxt = ST_DONE;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready  = (state_r == ST_IDLE);
    cfg_ready  = (state_r == ST_IDLE);
    out_tvalid = out_valid_r;
    out_tdata  = out_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      warm_r <= 16'd100;
      runlen_r <= 16'd1000;
      elim_r <= 16'sd768;
      slo_r <= -16'sd256;
      shi_r <= 16'sd256;
      gp_r <= '0; gd_r <= '0; gi_r <= '0;
      dp_r <= DELTA_INIT; dd_r <= DELTA_INIT; di_r <= DELTA_INIT;
      last_err_r <= '0; prev_err_r <= '0; esum_r <= '0; sq_r <= '0; step_r <= '0;
      best_r <= SQ_MAX;
      idx_r <= '0;
      pos_r <= 1'b1;
      trials_r <= '0;
      steer_r <= '0;
    end else begin
      state_r <= state_nxt;

      if (state_r == ST_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_KP_INIT:  gp_r <= $signed(cfg_data);
          CFG_KD_INIT:  gd_r <= $signed(cfg_data);
          CFG_KI_INIT:  gi_r <= $signed(cfg_data);
          CFG_WARMUP:   warm_r <= cfg_data[15:0];
          CFG_RUN_LEN:  runlen_r <= cfg_data[15:0];
          CFG_ERR_LIM:  elim_r <= $signed(cfg_data[15:0]);
          CFG_STEER_LO: slo_r <= $signed(cfg_data[15:0]);
          CFG_STEER_HI: shi_r <= $signed(cfg_data[15:0]);
          default: ;
        endcase
      end

      unique case (state_r)
        ST_IDLE: if (in_tvalid) begin
          cnt_r <= '0;
          acc_r <= '0;
          if (in_tuser == OP_SAMPLE) begin
            cont_r <= 1'b1;
            e_r <= e_in;
            de_r <= {e_in[15], e_in} - {prev_err_r[15], prev_err_r};
            prev_err_r <= e_in;
            last_err_r <= e_in;
            esum_r <= esum_new;
            step_r <= step_inc;
            mcand_r <= {{48{e_in[15]}}, e_in};
            mplier_r <= {{16{e_in[15]}}, e_in};
          end else begin
            cont_r <= eval_cont;
            quo_r <= (step_r <= warm_r) ? SQ_MAX : sq_r;
            rem_r <= '0;
            dvsr_r <= step_r - warm_r;
            div_scale_r <= 1'b0;
          end
        end
        ST_SQ_MUL, ST_MUL: begin
          acc_r <= acc_r + mul_add;
          if (state_r == ST_MUL && cnt_r == MUL_LAST) begin
            cnt_r <= '0;
            pass_r <= pass_r + 2'd1;
            if (pass_r == 2'd0) begin
              mcand_r <= {{40{gd_r[23]}}, gd_r};
              mplier_r <= {{15{de_r[16]}}, de_r};
            end else begin
              mcand_r <= {{40{gi_r[23]}}, gi_r};
              mplier_r <= esum_r;
            end
          end else begin
            mcand_r <= mcand_r <<< 1;
            mplier_r <= mplier_r >> 1;
            cnt_r <= cnt_r + 6'd1;
          end
        end
        ST_SQ_ADD: begin
          if (step_r >= warm_r) sq_r <= sq_wide[48] ? SQ_MAX : sq_wide[47:0];
          acc_r <= '0;
          cnt_r <= '0;
          pass_r <= '0;
          mcand_r <= {{40{gp_r[23]}}, gp_r};
          mplier_r <= {{16{e_r[15]}}, e_r};
        end
        ST_STEER: begin
          if (steer_s > 48'sd32767) steer_r <= 16'sh7FFF;
          else if (steer_s < -48'sd32768) steer_r <= 16'sh8000;
          else steer_r <= steer_s[15:0];
        end
        ST_DIV: begin
          rem_r <= rem_ge ? 16'(rem_sh - {1'b0, dvsr_r}) : rem_sh[15:0];
          quo_r <= {quo_r[46:0], rem_ge};
          cnt_r <= cnt_r + 6'd1;
        end
        ST_CMP: begin
          cnt_r <= '0;
          rem_r <= '0;
          dvsr_r <= 16'd10;
          div_scale_r <= 1'b1;
          priority if (improve) begin
            best_r <= quo_r;
            quo_r <= {20'd0, d_x11};
          end else if (pos_r) begin
            unique case (idx_r)
              2'd0: gp_r <= sat24(gain_minus2);
              2'd1: gd_r <= sat24(gain_minus2);
              default: gi_r <= sat24(gain_minus2);
            endcase
            pos_r <= 1'b0;
            step_r <= '0; last_err_r <= '0; prev_err_r <= '0; esum_r <= '0; sq_r <= '0;
            if (trials_r != 16'hFFFF) trials_r <= trials_r + 16'd1;
          end else begin
            unique case (idx_r)
              2'd0: gp_r <= sat24(gain_plus);
              2'd1: gd_r <= sat24(gain_plus);
              default: gi_r <= sat24(gain_plus);
            endcase
            quo_r <= {20'd0, d_x9};
          end
        end
        ST_DSTORE: begin
          unique case (idx_r)
            2'd0: dp_r <= delta_sat;
            2'd1: dd_r <= delta_sat;
            default: di_r <= delta_sat;
          endcase
          idx_r <= (idx_r == 2'(NUM_GAINS - 1)) ? 2'd0 : idx_r + 2'd1;
          step_r <= '0; last_err_r <= '0; prev_err_r <= '0; esum_r <= '0; sq_r <= '0;
        end
        ST_NEXT: begin
          // new gain under tuning steps up by its own delta
          unique case (idx_r)
            2'd0: gp_r <= sat24(gain_plus);
            2'd1: gd_r <= sat24(gain_plus);
            default: gi_r <= sat24(gain_plus);
          endcase
          pos_r <= 1'b1;
          if (trials_r != 16'hFFFF) trials_r <= trials_r + 16'd1;
        end
        ST_DONE: if (out_free)
          out_data_r <= {5'd0, trials_r, gi_r, gd_r, gp_r, idx_r, cont_r, steer_r};
        default: ;
      endcase
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n) idx_r != 2'd3)
    else $error("gain index out of range");
  a_delta_pos: assert property (@(posedge clk) disable iff (!rst_n)
    !dp_r[23] && !dd_r[23] && !di_r[23])
    else $error("delta went negative");
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second item taken while busy");
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside the done step");

endmodule
`default_nettype wire
